// File: design/stack_vm_instruction_execute_defines.svh
// Assertion macros shared by the stack machine RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef STACK_VM_INSTRUCTION_EXECUTE_DEFINES_SVH
`define STACK_VM_INSTRUCTION_EXECUTE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SVM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stack machine assertion failed");

// Next-cycle implication, disabled during reset.
`define SVM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stack machine assertion failed");

`endif

// File: design/svm_pkg.sv
// Package of the stack machine core: opcodes, sequencer states, status codes.
// Used by stack_vm_instruction_execute; depends on nothing.
`timescale 1ns / 1ps
package svm_pkg;

  localparam int unsigned MemWordsDef = 4096;
  localparam int unsigned PcBitsDef   = 16;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_EXIT = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_UNSP = 2'd3;

  typedef enum logic [5:0] {
    OP_LEA, OP_IMM, OP_JMP, OP_CALL, OP_JZ, OP_JNZ, OP_ENT, OP_ADJ, OP_LEV,
    OP_LI, OP_LC, OP_SI, OP_SC, OP_PUSH,
    OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE,
    OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
    OP_OPEN, OP_READ, OP_CLOS, OP_PRTF, OP_MALC, OP_MSET, OP_MCMP, OP_EXIT
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_DIV, S_OUT
  } state_e;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

endpackage

// File: design/svm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module svm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: design/stack_vm_instruction_execute.sv
// Top level of the stack machine core: sequencer, registers and divider.
// Depends on svm_pkg, svm_ram and stack_vm_instruction_execute_defines.svh.
`timescale 1ns / 1ps
`include "stack_vm_instruction_execute_defines.svh"

// Executes one instruction per request and returns one result per request. After reset
// the block clears its data memory, one word a cycle, and takes no request meanwhile.
// Every request passes through the single-port memory sequencer: an instruction without
// memory access or with only a push goes from S_IDLE straight to S_OUT, a single stack or
// memory read passes S_RD1, LEV and SC pass S_RD1 and S_RD2, and DIV or MOD pass S_RD1 and
// then S_DIV, the one-bit-per-cycle shared divider, unless the divisor is zero. The next
// request is taken only after the result has been taken.
module stack_vm_instruction_execute #(
  parameter int unsigned MEM_WORDS = svm_pkg::MemWordsDef,
  parameter int unsigned PC_BITS   = svm_pkg::PcBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [5:0]         opcode_i,
  input  logic signed [31:0] operand_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        next_pc_o,
  output logic signed [31:0] accumulator_out_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] exit_value_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  svm_pkg::state_e state_q, state_d;
  svm_pkg::op_e    op_q, op_d, op_in;

  logic [PC_BITS-1:0] pc_q, pc_d, pc_p1, pc_p2;
  logic [31:0] acc_q, acc_d, sp_q, sp_d, fp_q, fp_d, fin_q, fin_d, tmp_q, tmp_d;
  logic [1:0]  halt_q, halt_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic [31:0] opnd, opnd4, sp_m4, rd, pc_ext;
  logic [32:0] div_sh, div_diff;
  logic [31:0] rem_n, quo_n, byte_mask, byte_new;
  logic [4:0]  shr_cnt;
  logic [4:0]  lane_sh;

  svm_ram #(.Width(32), .Depth(MEM_WORDS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign op_in   = svm_pkg::op_e'(opcode_i);
  assign opnd    = operand_i;
  assign opnd4   = {opnd[29:0], 2'b00};
  assign sp_m4   = sp_q - 32'd4;
  assign pc_p1   = pc_q + PC_BITS'(1);
  assign pc_p2   = pc_q + PC_BITS'(2);
  assign rd      = ram_rdata;
  assign shr_cnt = (acc_q > 32'd31) ? 5'd31 : acc_q[4:0];

  assign div_sh   = {rem_q, quo_q[31]};
  assign div_diff = div_sh - {1'b0, dvs_q};
  assign rem_n    = div_diff[32] ? div_sh[31:0] : div_diff[31:0];
  assign quo_n    = {quo_q[30:0], ~div_diff[32]};

  assign lane_sh   = {tmp_q[1:0], 3'b000};
  assign byte_mask = 32'hFF << lane_sh;
  assign byte_new  = (rd & ~byte_mask) | ({24'd0, acc_q[7:0]} << lane_sh);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pc_d      = pc_q;
    acc_d     = acc_q;
    sp_d      = sp_q;
    fp_d      = fp_q;
    fin_d     = fin_q;
    tmp_d     = tmp_q;
    halt_d    = halt_q;
    clr_d     = clr_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_addr  = sp_q[AW+1:2];
    ram_wdata = 32'd0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      svm_pkg::S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(MEM_WORDS - 1)) begin
          state_d = svm_pkg::S_IDLE;
        end
      end
      svm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = op_in;
          state_d = svm_pkg::S_OUT;
          if (halt_q == svm_pkg::ST_RUN) begin
            unique case (op_in)
              svm_pkg::OP_LEA: begin
                acc_d = fp_q + opnd4;
                pc_d  = pc_p2;
              end
              svm_pkg::OP_IMM: begin
                acc_d = opnd;
                pc_d  = pc_p2;
              end
              svm_pkg::OP_JMP: pc_d = opnd[PC_BITS-1:0];
              svm_pkg::OP_CALL: begin
                sp_d      = sp_m4;
                ram_we    = 1'b1;
                ram_addr  = sp_m4[AW+1:2];
                ram_wdata = 32'(pc_p2);
                pc_d      = opnd[PC_BITS-1:0];
              end
              svm_pkg::OP_JZ:  pc_d = (acc_q != 32'd0) ? pc_p2 : opnd[PC_BITS-1:0];
              svm_pkg::OP_JNZ: pc_d = (acc_q != 32'd0) ? opnd[PC_BITS-1:0] : pc_p2;
              svm_pkg::OP_ENT: begin
                ram_we    = 1'b1;
                ram_addr  = sp_m4[AW+1:2];
                ram_wdata = fp_q;
                fp_d      = sp_m4;
                sp_d      = sp_m4 - opnd4;
                pc_d      = pc_p2;
              end
              svm_pkg::OP_ADJ: begin
                sp_d = sp_q + opnd4;
                pc_d = pc_p2;
              end
              svm_pkg::OP_LEV: begin
                ram_addr = fp_q[AW+1:2];
                state_d  = svm_pkg::S_RD1;
              end
              svm_pkg::OP_LI, svm_pkg::OP_LC: begin
                ram_addr = acc_q[AW+1:2];
                pc_d     = pc_p1;
                state_d  = svm_pkg::S_RD1;
              end
              svm_pkg::OP_PUSH: begin
                sp_d      = sp_m4;
                ram_we    = 1'b1;
                ram_addr  = sp_m4[AW+1:2];
                ram_wdata = acc_q;
                pc_d      = pc_p1;
              end
              svm_pkg::OP_SI, svm_pkg::OP_SC, svm_pkg::OP_EXIT,
              svm_pkg::OP_OR, svm_pkg::OP_XOR, svm_pkg::OP_AND, svm_pkg::OP_EQ,
              svm_pkg::OP_NE, svm_pkg::OP_LT, svm_pkg::OP_GT, svm_pkg::OP_LE,
              svm_pkg::OP_GE, svm_pkg::OP_SHL, svm_pkg::OP_SHR, svm_pkg::OP_ADD,
              svm_pkg::OP_SUB, svm_pkg::OP_MUL, svm_pkg::OP_DIV, svm_pkg::OP_MOD: begin
                ram_addr = sp_q[AW+1:2];
                pc_d     = pc_p1;
                state_d  = svm_pkg::S_RD1;
              end
              default: begin
                halt_d = svm_pkg::ST_UNSP;
                pc_d   = pc_p1;
              end
            endcase
          end
        end
      end
      svm_pkg::S_RD1: begin
        state_d = svm_pkg::S_OUT;
        unique case (op_q)
          svm_pkg::OP_LI: acc_d = rd;
          svm_pkg::OP_LC: acc_d = svm_pkg::sext8(8'(rd >> {acc_q[1:0], 3'b000}));
          svm_pkg::OP_EXIT: begin
            fin_d  = rd;
            halt_d = svm_pkg::ST_EXIT;
          end
          svm_pkg::OP_LEV: begin
            fp_d     = rd;
            sp_d     = fp_q + 32'd8;
            ram_addr = fp_q[AW+1:2] + AW'(1);
            state_d  = svm_pkg::S_RD2;
          end
          svm_pkg::OP_SI: begin
            sp_d      = sp_q + 32'd4;
            ram_we    = 1'b1;
            ram_addr  = rd[AW+1:2];
            ram_wdata = acc_q;
          end
          svm_pkg::OP_SC: begin
            sp_d     = sp_q + 32'd4;
            tmp_d    = rd;
            ram_addr = rd[AW+1:2];
            state_d  = svm_pkg::S_RD2;
          end
          svm_pkg::OP_OR:  begin sp_d = sp_q + 32'd4; acc_d = rd | acc_q; end
          svm_pkg::OP_XOR: begin sp_d = sp_q + 32'd4; acc_d = rd ^ acc_q; end
          svm_pkg::OP_AND: begin sp_d = sp_q + 32'd4; acc_d = rd & acc_q; end
          svm_pkg::OP_EQ:  begin sp_d = sp_q + 32'd4; acc_d = 32'(rd == acc_q); end
          svm_pkg::OP_NE:  begin sp_d = sp_q + 32'd4; acc_d = 32'(rd != acc_q); end
          svm_pkg::OP_LT: begin
            sp_d  = sp_q + 32'd4;
            acc_d = 32'($signed(rd) < $signed(acc_q));
          end
          svm_pkg::OP_GT: begin
            sp_d  = sp_q + 32'd4;
            acc_d = 32'($signed(rd) > $signed(acc_q));
          end
          svm_pkg::OP_LE: begin
            sp_d  = sp_q + 32'd4;
            acc_d = 32'($signed(rd) <= $signed(acc_q));
          end
          svm_pkg::OP_GE: begin
            sp_d  = sp_q + 32'd4;
            acc_d = 32'($signed(rd) >= $signed(acc_q));
          end
          svm_pkg::OP_SHL: begin
            sp_d  = sp_q + 32'd4;
            acc_d = (acc_q > 32'd31) ? 32'd0 : (rd << acc_q[4:0]);
          end
          svm_pkg::OP_SHR: begin
            sp_d  = sp_q + 32'd4;
            acc_d = 32'($signed(rd) >>> shr_cnt);
          end
          svm_pkg::OP_ADD: begin sp_d = sp_q + 32'd4; acc_d = rd + acc_q; end
          svm_pkg::OP_SUB: begin sp_d = sp_q + 32'd4; acc_d = rd - acc_q; end
          svm_pkg::OP_MUL: begin sp_d = sp_q + 32'd4; acc_d = rd * acc_q; end
          svm_pkg::OP_DIV, svm_pkg::OP_MOD: begin
            sp_d = sp_q + 32'd4;
            if (acc_q == 32'd0) begin
              halt_d = svm_pkg::ST_DIV0;
            end else begin
              tmp_d   = rd;
              rem_d   = 32'd0;
              quo_d   = rd[31] ? (32'd0 - rd) : rd;
              dvs_d   = acc_q[31] ? (32'd0 - acc_q) : acc_q;
              cnt_d   = 5'd0;
              state_d = svm_pkg::S_DIV;
            end
          end
          default: ;
        endcase
      end
      svm_pkg::S_RD2: begin
        state_d = svm_pkg::S_OUT;
        if (op_q == svm_pkg::OP_LEV) begin
          pc_d = rd[PC_BITS-1:0];
        end else begin
          ram_we    = 1'b1;
          ram_addr  = tmp_q[AW+1:2];
          ram_wdata = byte_new;
          acc_d     = svm_pkg::sext8(acc_q[7:0]);
        end
      end
      svm_pkg::S_DIV: begin
        rem_d = rem_n;
        quo_d = quo_n;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = svm_pkg::S_OUT;
          if (op_q == svm_pkg::OP_DIV) begin
            acc_d = ((tmp_q[31] ^ acc_q[31]) != 1'b0) ? (32'd0 - quo_n) : quo_n;
          end else begin
            acc_d = tmp_q[31] ? (32'd0 - rem_n) : rem_n;
          end
        end
      end
      svm_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = svm_pkg::S_IDLE;
        end
      end
      default: state_d = svm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svm_pkg::S_CLEAR;
      op_q    <= svm_pkg::OP_LEA;
      pc_q    <= '0;
      acc_q   <= 32'd0;
      sp_q    <= 32'(MEM_WORDS) << 2;
      fp_q    <= 32'(MEM_WORDS) << 2;
      fin_q   <= 32'd0;
      halt_q  <= svm_pkg::ST_RUN;
      clr_q   <= '0;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      pc_q    <= cfg_we_i ? PC_BITS'(cfg_wdata_i) : pc_d;
      acc_q   <= acc_d;
      sp_q    <= sp_d;
      fp_q    <= fp_d;
      fin_q   <= fin_d;
      halt_q  <= halt_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign pc_ext            = 32'(pc_q);
  assign next_pc_o         = pc_ext[15:0];
  assign accumulator_out_o = acc_q;
  assign status_o          = halt_q;
  assign exit_value_o      = (halt_q == svm_pkg::ST_EXIT) ? fin_q : 32'd0;

  `SVM_ASSERT_NOW(a_ready_excl_valid, in_ready_o, !out_valid_o)
  `SVM_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  `SVM_ASSERT_NOW(a_no_req_in_clear, state_q == svm_pkg::S_CLEAR, !in_ready_o)
  `SVM_ASSERT_NEXT(a_halt_sticks, halt_q != svm_pkg::ST_RUN, halt_q == $past(halt_q))

endmodule
